// ===== src/cles_pkg.sv =====
// Shared types and constants for the character-LCD expander sequencer.
// Used by cles_ctrl, cles_datapath and the top level. No dependencies.
`default_nettype none

package cles_pkg;

  // request opcodes
  localparam logic [3:0] OP_INIT      = 4'd0;
  localparam logic [3:0] OP_CMD       = 4'd1;
  localparam logic [3:0] OP_DATA      = 4'd2;
  localparam logic [3:0] OP_CURSOR    = 4'd3;
  localparam logic [3:0] OP_FLAG      = 4'd4;
  localparam logic [3:0] OP_BACKLIGHT = 4'd5;
  localparam logic [3:0] OP_CLEAR     = 4'd6;
  localparam logic [3:0] OP_HOME      = 4'd7;
  localparam logic [3:0] OP_GLYPH     = 4'd8;

  // configuration register indexes
  localparam logic CFG_PULSE_WAIT  = 1'b0;
  localparam logic CFG_SETTLE_WAIT = 1'b1;

  // display flag selects
  localparam logic [1:0] FSEL_DISPLAY = 2'd0;
  localparam logic [1:0] FSEL_CURSOR  = 2'd1;
  localparam logic [1:0] FSEL_BLINK   = 2'd2;

  localparam logic [7:0] PULSE_WAIT_RESET  = 8'd1;
  localparam logic [7:0] SETTLE_WAIT_RESET = 8'd50;
  localparam logic [2:0] FLAGS_RESET       = 3'd4;

  // LCD controller command bytes and extra waits (microseconds)
  localparam logic [7:0] LCD_WAKE       = 8'h30;
  localparam logic [7:0] LCD_FOUR_BIT   = 8'h20;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_DISP_CTRL  = 8'h08;
  localparam logic [7:0] LCD_CLR_DISP   = 8'h01;
  localparam logic [7:0] LCD_GO_HOME    = 8'h02;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_SET_CGRAM  = 8'h40;
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;

  localparam logic [12:0] WAIT_POWER_UP = 13'd4500;
  localparam logic [12:0] WAIT_WAKE     = 13'd200;
  localparam logic [12:0] WAIT_CMD      = 13'd80;
  localparam logic [12:0] WAIT_LONG     = 13'd2000;

  // last unit index of the multi-unit requests
  localparam logic [3:0] INIT_LAST_UNIT  = 4'd8;
  localparam logic [3:0] GLYPH_LAST_UNIT = 4'd9;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the request in, update kept state, rewind step counters
    logic issue;    // load the current write into the output register
  } cles_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or being taken
    logic last_write;  // current write ends the request
  } cles_status_t;

  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] off;
    case (r)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== src/char_lcd_expander_sequencer.sv =====
// Top level of the character-LCD expander sequencer (4-bit LCD bus behind an I/O expander).
// Instantiates cles_ctrl and cles_datapath; uses cles_pkg.
//
//   port group   dir  handshake            payload
//   request      in   in_valid / in_ready  opcode .. glyph_rows
//   expander     out  out_valid/out_ready  expander_byte, wait_us, last
//   config       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One expander word leaves per cycle from a single output register while the output is not
// stalled; an ordinary byte request gives 4 words, backlight 1, init 28, glyph load 40.
// The next request is taken on the edge that issues the final word of the current one.
// Opcodes 9 to 15 are taken and give no word.
// A stalled output register holds the sequence; rst is synchronous and needs no sweep.
`default_nettype none

module char_lcd_expander_sequencer
  import cles_pkg::*;
#(
  parameter int ROW_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic [6:0]  column,
  input  wire logic [1:0]  row,
  input  wire logic [1:0]  flag_select,
  input  wire logic        flag_value,
  input  wire logic [2:0]  glyph_slot,
  input  wire logic [63:0] glyph_rows,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       expander_byte,
  output logic [12:0]      wait_us,
  output logic             last
);

  cles_cmd_t    cmd;
  cles_status_t status;

  assign cfg_ready = 1'b1;

  cles_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cles_datapath #(
    .ROW_COUNT (ROW_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .column        (column),
    .row           (row),
    .flag_select   (flag_select),
    .flag_value    (flag_value),
    .glyph_slot    (glyph_slot),
    .glyph_rows    (glyph_rows),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .expander_byte (expander_byte),
    .wait_us       (wait_us),
    .last          (last)
  );

  // a command byte needs four words, so the request port closes after taking one
  a_cmd_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_CMD) |=> !in_ready)
    else $error("request port open during a command byte");

  // an enable-high word is never the final word
  a_en_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && expander_byte[2] |-> !last)
    else $error("enable-high word marked last");

  // bit 1 of the expander is unused
  a_bit1_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !expander_byte[1])
    else $error("unused expander bit set");

endmodule

`default_nettype wire

// ===== src/cles_ctrl.sv =====
// Request controller: idle / run state machine driving the datapath.
// Depends on cles_pkg for opcodes and the command and status structs.
`default_nettype none

module cles_ctrl
  import cles_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [3:0]   opcode,
  output logic              in_ready,
  input  wire cles_status_t status,
  output cles_cmd_t         cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic issue;
  logic capture;

  always_comb begin
    issue    = (state == ST_RUN) && status.out_free;
    // take the next request on the same edge as the final word of this one
    in_ready = (state == ST_IDLE) || (issue && status.last_write);
    capture  = in_valid && in_ready;

    state_next = state;
    if (capture && (opcode <= OP_GLYPH)) begin
      state_next = ST_RUN;
    end else if (capture || (issue && status.last_write)) begin
      state_next = ST_IDLE;
    end

    cmd.capture = capture;
    cmd.issue   = issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/cles_datapath.sv =====
// Datapath: request registers, kept LCD state, wait registers, step counters,
// write builder and output register. Depends on cles_pkg.
`default_nettype none

module cles_datapath
  import cles_pkg::*;
#(
  parameter int ROW_COUNT = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cles_cmd_t    cmd,
  output cles_status_t      status,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire logic [3:0]   opcode,
  input  wire logic [7:0]   data_byte,
  input  wire logic [6:0]   column,
  input  wire logic [1:0]   row,
  input  wire logic [1:0]   flag_select,
  input  wire logic         flag_value,
  input  wire logic [2:0]   glyph_slot,
  input  wire logic [63:0]  glyph_rows,
  input  wire logic         out_ready,
  output logic              out_valid,
  output logic [7:0]        expander_byte,
  output logic [12:0]       wait_us,
  output logic              last
);

  // captured request
  logic [3:0]  op;
  logic [7:0]  dbyte;
  logic [6:0]  col;
  logic [1:0]  row_r;
  logic        fval;
  logic [2:0]  slot;
  logic [63:0] rows;

  // kept state and registers
  logic        backlight_on;
  logic [2:0]  display_flags;
  logic [7:0]  pulse_wait;
  logic [7:0]  settle_wait;

  // step counters: unit is one byte or one lone nibble, phase is the word within it
  logic [3:0]  unit;
  logic [1:0]  phase;

  logic [1:0]  row_eff;
  logic [7:0]  cursor_addr;
  logic [2:0]  glyph_idx;
  logic [7:0]  glyph_byte;
  logic [7:0]  u_value;
  logic        u_rs;
  logic [12:0] u_extra;
  logic        u_nib_only;
  logic [3:0]  final_unit;
  logic        unit_done;
  logic [3:0]  nibble;
  logic [7:0]  word_byte;
  logic [12:0] word_wait;
  logic        word_last;
  logic [2:0]  flag_mask;

  always_comb begin
    if (ROW_COUNT <= 1) begin
      row_eff = 2'd0;
    end else if ({30'd0, row_r} >= ROW_COUNT) begin
      row_eff = row_r - 2'(ROW_COUNT);
    end else begin
      row_eff = row_r;
    end
    cursor_addr = LCD_SET_DDRAM | ({1'b0, col} + row_offset(row_eff));
    glyph_idx   = 3'(unit - 4'd1);
    glyph_byte  = 8'(rows >> {glyph_idx, 3'b000});
  end

  // per-unit byte, RS, extra wait and nibble-only mark
  always_comb begin
    u_value    = 8'h00;
    u_rs       = 1'b0;
    u_extra    = 13'd0;
    u_nib_only = 1'b0;
    final_unit = 4'd0;
    case (op)
      OP_INIT: begin
        final_unit = INIT_LAST_UNIT;
        case (unit)
          4'd0: begin u_value = LCD_WAKE; u_extra = WAIT_POWER_UP; u_nib_only = 1'b1; end
          4'd1: begin u_value = LCD_WAKE; u_extra = WAIT_WAKE; u_nib_only = 1'b1; end
          4'd2: begin u_value = LCD_WAKE; u_extra = WAIT_WAKE; u_nib_only = 1'b1; end
          4'd3: begin u_value = LCD_FOUR_BIT; u_extra = WAIT_WAKE; u_nib_only = 1'b1; end
          4'd4: begin u_value = LCD_FUNC_SET; u_extra = WAIT_CMD; end
          4'd5: begin u_value = LCD_DISP_CTRL; u_extra = WAIT_CMD; end
          4'd6: begin u_value = LCD_CLR_DISP; u_extra = WAIT_LONG; end
          4'd7: begin u_value = LCD_ENTRY_MODE; u_extra = WAIT_CMD; end
          default: begin
            u_value = LCD_DISP_CTRL | {5'd0, display_flags};
            u_extra = WAIT_CMD;
          end
        endcase
      end
      OP_CMD:    u_value = dbyte;
      OP_DATA: begin
        u_value = dbyte;
        u_rs    = 1'b1;
      end
      OP_CURSOR: u_value = cursor_addr;
      OP_FLAG:   u_value = LCD_DISP_CTRL | {5'd0, display_flags};
      OP_CLEAR: begin
        u_value = LCD_CLR_DISP;
        u_extra = WAIT_LONG;
      end
      OP_HOME: begin
        u_value = LCD_GO_HOME;
        u_extra = WAIT_LONG;
      end
      OP_GLYPH: begin
        final_unit = GLYPH_LAST_UNIT;
        if (unit == 4'd0) begin
          u_value = LCD_SET_CGRAM | {2'b00, slot, 3'b000};
        end else if (unit == GLYPH_LAST_UNIT) begin
          u_value = LCD_SET_DDRAM;
        end else begin
          u_value = glyph_byte;
          u_rs    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // build the current word
  always_comb begin
    unit_done = u_nib_only ? (phase == 2'd1) : (phase == 2'd3);
    nibble    = phase[1] ? u_value[3:0] : u_value[7:4];
    if (op == OP_BACKLIGHT) begin
      word_byte = {4'h0, fval, 3'b000};
      word_wait = 13'd0;
      word_last = 1'b1;
    end else begin
      word_byte = {nibble, backlight_on, ~phase[0], 1'b0, u_rs};
      if (!phase[0]) begin
        word_wait = {5'd0, pulse_wait};
      end else begin
        word_wait = {5'd0, settle_wait} + (unit_done ? u_extra : 13'd0);
      end
      word_last = unit_done && (unit == final_unit);
    end
    status.out_free   = !out_valid || out_ready;
    status.last_write = word_last;
  end

  always_comb begin
    case (flag_select)
      FSEL_DISPLAY: flag_mask = 3'b100;
      FSEL_CURSOR:  flag_mask = 3'b010;
      FSEL_BLINK:   flag_mask = 3'b001;
      default:      flag_mask = 3'b000;
    endcase
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= opcode;
      dbyte <= data_byte;
      col   <= column;
      row_r <= row;
      fval  <= flag_value;
      slot  <= glyph_slot;
      rows  <= glyph_rows;
    end
  end

  // kept state, waits, counters, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on  <= 1'b1;
      display_flags <= FLAGS_RESET;
      pulse_wait    <= PULSE_WAIT_RESET;
      settle_wait   <= SETTLE_WAIT_RESET;
      unit          <= 4'd0;
      phase         <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PULSE_WAIT:  pulse_wait  <= cfg_data;
          CFG_SETTLE_WAIT: settle_wait <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        unit  <= 4'd0;
        phase <= 2'd0;
        case (opcode)
          OP_INIT: begin
            backlight_on  <= 1'b1;
            display_flags <= FLAGS_RESET;
          end
          OP_FLAG: begin
            if (flag_value) begin
              display_flags <= display_flags | flag_mask;
            end else begin
              display_flags <= display_flags & ~flag_mask;
            end
          end
          OP_BACKLIGHT: backlight_on <= flag_value;
          default: ;
        endcase
      end else if (cmd.issue && !word_last) begin
        if (unit_done) begin
          unit  <= unit + 4'd1;
          phase <= 2'd0;
        end else begin
          phase <= phase + 2'd1;
        end
      end
      if (cmd.issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      expander_byte <= word_byte;
      wait_us       <= word_wait;
      last          <= word_last;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for char_lcd_expander_sequencer: LCD requests in, expander words out.
// Predicts every word from its own copy of the backlight, flags and timing registers.
// Depends on cles_pkg and the RTL under src only.
`timescale 1ns / 1ps

module tb
  import cles_pkg::*;
;

  localparam logic [3:0]  OP_RSVD_LO = 4'd9;
  localparam logic [3:0]  OP_RSVD_HI = 4'd15;
  localparam logic [1:0]  FSEL_NONE  = 2'd3;
  localparam logic [7:0]  EN_BIT     = 8'h04;
  localparam logic [7:0]  BL_BIT     = 8'h08;
  localparam logic [7:0]  NO_BYTE    = 8'h00;
  localparam logic [12:0] NO_WAIT    = 13'd0;
  localparam logic [63:0] ROWS_NONE  = '0;
  localparam logic [63:0] ROWS_ALL   = '1;
  localparam logic [3:0][7:0] ROW_BASE = {8'h54, 8'h14, 8'h40, 8'h00};
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_SLACK = 8;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  data_byte;
    logic [6:0]  column;
    logic [1:0]  row;
    logic [1:0]  flag_select;
    logic        flag_value;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0]  xbyte;
    logic [12:0] delay_us;
    logic        is_last;
  } lcd_write_t;

  // typed rows carry their own expectation: one word, or none at all
  typedef struct packed {
    lcd_req_t    req;
    logic        typed;
    logic        yields;
    logic [7:0]  xbyte;
    logic [12:0] delay_us;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PULSE_WAIT;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = OP_INIT;
  logic [7:0]  data_byte = '0;
  logic [6:0]  column = '0;
  logic [1:0]  row = '0;
  logic [1:0]  flag_select = FSEL_DISPLAY;
  logic        flag_value = 1'b0;
  logic [2:0]  glyph_slot = '0;
  logic [63:0] glyph_rows = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  expander_byte;
  logic [12:0] wait_us;
  logic        last;

  // predictor state
  logic        bl_on = 1'b1;
  logic [2:0]  disp_flags = FLAGS_RESET;
  logic [7:0]  pulse_us = PULSE_WAIT_RESET;
  logic [7:0]  settle_us = SETTLE_WAIT_RESET;

  lcd_write_t  writes_due[$];
  int          errors = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          long_hold_req = 1'b0;
  int          hold_left = 0;

  directed_row_t directed_tbl [N_DIRECTED];

  char_lcd_expander_sequencer u_top (.*);

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void push_write(input logic [7:0] b, input logic [12:0] d);
    lcd_write_t w;
    w.xbyte    = b;
    w.delay_us = d;
    w.is_last  = 1'b0;
    writes_due.push_back(w);
  endfunction

  function automatic void push_nibble(input logic [7:0] nib, input logic rs,
                                      input logic [12:0] extra);
    logic [7:0] b;
    b = {nib[7:4], bl_on, 2'b00, rs};
    push_write(b | EN_BIT, {5'd0, pulse_us});
    push_write(b, {5'd0, settle_us} + extra);
  endfunction

  function automatic void push_byte(input logic [7:0] v, input logic rs,
                                    input logic [12:0] extra);
    push_nibble({v[7:4], 4'h0}, rs, NO_WAIT);
    push_nibble({v[3:0], 4'h0}, rs, extra);
  endfunction

  function automatic void predict_writes(input lcd_req_t r);
    int         n0;
    logic [2:0] mask;
    logic [7:0] addr;
    lcd_write_t w;
    n0 = writes_due.size();
    case (r.opcode)
      OP_INIT: begin
        bl_on      = 1'b1;
        disp_flags = FLAGS_RESET;
        push_nibble(LCD_WAKE, 1'b0, WAIT_POWER_UP);
        push_nibble(LCD_WAKE, 1'b0, WAIT_WAKE);
        push_nibble(LCD_WAKE, 1'b0, WAIT_WAKE);
        push_nibble(LCD_FOUR_BIT, 1'b0, WAIT_WAKE);
        push_byte(LCD_FUNC_SET, 1'b0, WAIT_CMD);
        push_byte(LCD_DISP_CTRL, 1'b0, WAIT_CMD);
        push_byte(LCD_CLR_DISP, 1'b0, WAIT_LONG);
        push_byte(LCD_ENTRY_MODE, 1'b0, WAIT_CMD);
        push_byte(LCD_DISP_CTRL | {5'd0, disp_flags}, 1'b0, WAIT_CMD);
      end
      OP_CMD:  push_byte(r.data_byte, 1'b0, NO_WAIT);
      OP_DATA: push_byte(r.data_byte, 1'b1, NO_WAIT);
      OP_CURSOR: begin
        addr = {1'b0, r.column} + ROW_BASE[r.row];
        push_byte(LCD_SET_DDRAM | addr, 1'b0, NO_WAIT);
      end
      OP_FLAG: begin
        case (r.flag_select)
          FSEL_DISPLAY: mask = 3'b100;
          FSEL_CURSOR:  mask = 3'b010;
          FSEL_BLINK:   mask = 3'b001;
          default:      mask = 3'b000;
        endcase
        if (r.flag_value) disp_flags = disp_flags | mask;
        else disp_flags = disp_flags & ~mask;
        push_byte(LCD_DISP_CTRL | {5'd0, disp_flags}, 1'b0, NO_WAIT);
      end
      OP_BACKLIGHT: begin
        bl_on = r.flag_value;
        push_write(r.flag_value ? BL_BIT : NO_BYTE, NO_WAIT);
      end
      OP_CLEAR: push_byte(LCD_CLR_DISP, 1'b0, WAIT_LONG);
      OP_HOME:  push_byte(LCD_GO_HOME, 1'b0, WAIT_LONG);
      OP_GLYPH: begin
        push_byte(LCD_SET_CGRAM | {2'b00, r.glyph_slot, 3'b000}, 1'b0, NO_WAIT);
        for (int i = 0; i < 8; i++) push_byte(r.glyph_rows[8*i +: 8], 1'b1, NO_WAIT);
        push_byte(LCD_SET_DDRAM, 1'b0, NO_WAIT);
      end
      default: ;
    endcase
    // flag the closing word of the request
    if (writes_due.size() > n0) begin
      w = writes_due.pop_back();
      w.is_last = 1'b1;
      writes_due.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin : expander_side
    lcd_write_t due;
    if (!rst && out_valid && out_ready) begin
      if (writes_due.size() == 0) begin
        $error("unexpected expander word %02h", expander_byte);
        errors++;
      end else begin
        due = writes_due.pop_front();
        if (expander_byte !== due.xbyte) begin
          $error("expander_byte: expected %02h, got %02h", due.xbyte, expander_byte);
          errors++;
        end
        if (wait_us !== due.delay_us) begin
          $error("wait_us: expected %0d, got %0d", due.delay_us, wait_us);
          errors++;
        end
        if (last !== due.is_last) begin
          $error("last: expected %0b, got %0b", due.is_last, last);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!rx_stalls || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_request(input lcd_req_t r, output int n_before);
    opcode      <= r.opcode;
    data_byte   <= r.data_byte;
    column      <= r.column;
    row         <= r.row;
    flag_select <= r.flag_select;
    flag_value  <= r.flag_value;
    glyph_slot  <= r.glyph_slot;
    glyph_rows  <= r.glyph_rows;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_before = writes_due.size();
    predict_writes(r);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (tx_gaps && $urandom_range(0, 99) >= 55)
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drop valid, let every due word arrive, then allow for a silent request
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] pulse, input logic [7:0] settle);
    cfg_index <= CFG_PULSE_WAIT;
    cfg_data  <= pulse;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pulse_us = pulse;
    cfg_index <= CFG_SETTLE_WAIT;
    cfg_data  <= settle;
    do @(posedge clk); while (!cfg_ready);
    settle_us = settle;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_CMD;
    if (r < 45) return OP_DATA;
    if (r < 60) return OP_CURSOR;
    if (r < 72) return OP_FLAG;
    if (r < 78) return OP_BACKLIGHT;
    if (r < 83) return OP_CLEAR;
    if (r < 87) return OP_HOME;
    if (r < 93) return OP_GLYPH;
    if (r < 96) return OP_INIT;
    return 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
  endfunction

  function automatic lcd_req_t rand_request(input logic [3:0] op);
    lcd_req_t r;
    r.opcode      = op;
    r.data_byte   = 8'($urandom);
    r.column      = 7'($urandom);
    r.row         = 2'($urandom);
    r.flag_select = 2'($urandom);
    r.flag_value  = 1'($urandom);
    r.glyph_slot  = 3'($urandom);
    r.glyph_rows  = {$urandom, $urandom};
    return r;
  endfunction

  // ignored opcodes do not count toward the item total
  task automatic run_random(input int n_items);
    int       sent;
    int       n0;
    lcd_req_t r;
    sent = 0;
    while (sent < n_items) begin
      r = rand_request(pick_opcode());
      send_request(r, n0);
      if (r.opcode <= OP_GLYPH) sent++;
      sender_gap();
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin : stimulus
    int         n0;
    lcd_write_t w;
    directed_tbl = '{
      // request: opcode, byte, column, row, flag select, flag value, slot, glyph rows
      '{{OP_CLEAR,     8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_HOME,      8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CMD,       8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CMD,       8'hFF, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_DATA,      8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_DATA,      8'hFF, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CURSOR,    8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CURSOR,    8'h00, 7'd127, 2'd1, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CURSOR,    8'h00, 7'd127, 2'd3, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CURSOR,    8'h00, 7'd100, 2'd2, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_CURSOR,  1'b1, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_BLINK,   1'b1, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      // no flag selected: the control command still goes out unchanged
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_NONE,    1'b1, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b1, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_BACKLIGHT, 8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b1, 1'b1, NO_BYTE, NO_WAIT},
      '{{OP_DATA,      8'hA5, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_GLYPH,     8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_BACKLIGHT, 8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b1, 3'd0, ROWS_NONE},
        1'b1, 1'b1, BL_BIT, NO_WAIT},
      '{{OP_GLYPH,     8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd7, ROWS_ALL},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_RSVD_LO,   8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b1, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_RSVD_HI,   8'hFF, 7'd127, 2'd3, FSEL_NONE,    1'b1, 3'd7, ROWS_ALL},
        1'b1, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_INIT,      8'h00, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_FLAG,      8'h00, 7'd0,   2'd0, FSEL_BLINK,   1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT},
      '{{OP_CMD,       8'h5A, 7'd0,   2'd0, FSEL_DISPLAY, 1'b0, 3'd0, ROWS_NONE},
        1'b0, 1'b0, NO_BYTE, NO_WAIT}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset timing
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(directed_tbl[i].req, n0);
      if (directed_tbl[i].typed) begin
        while (writes_due.size() > n0) void'(writes_due.pop_back());
        if (directed_tbl[i].yields) begin
          w.xbyte    = directed_tbl[i].xbyte;
          w.delay_us = directed_tbl[i].delay_us;
          w.is_last  = 1'b1;
          writes_due.push_back(w);
        end
      end
      sender_gap();
    end
    wait_idle();

    // zero waits, back to back on both sides
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_timing(8'h00, 8'h00);
    run_random(45);
    wait_idle();

    // longest waits; init here gives the largest wait value
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    set_timing(8'hFF, 8'hFF);
    send_request(rand_request(OP_INIT), n0);
    sender_gap();
    run_random(20);
    // hold the output off and keep offering requests until the input backs up
    long_hold_req = 1'b1;
    tx_gaps = 1'b0;
    run_random(8);
    tx_gaps = 1'b1;
    wait_idle();
    run_random(30);
    wait_idle();

    set_timing(8'($urandom), 8'($urandom));
    run_random(45);
    wait_idle();

    set_timing(8'($urandom), 8'($urandom));
    run_random(35);
    wait_idle();

    if (errors == 0 && writes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
